@@ rtl/core/prr_pkg.sv @@
// ============================================================================
// prr_pkg: shared types and constants for the polyphase rational resampler
// Beat layouts for both channels, configuration register indexes, command
// codes and the field widths that the channels fix.
// ============================================================================
`default_nettype none

package prr_pkg;

    // Field widths fixed by the channel layout.
    localparam int SAMPLE_WIDTH     = 16;
    localparam int COEF_INDEX_WIDTH = 9;
    localparam int RATIO_WIDTH      = 6;
    localparam int TAPS_WIDTH       = 10;
    localparam int PHASE_WIDTH      = 6;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH   = 10;
    localparam int RATIO_MAX        = 32;

    // Defaults for the top-level storage parameters.
    localparam int DEFAULT_MAX_TAPS      = 512;
    localparam int DEFAULT_HISTORY_DEPTH = 512;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP_FACTOR    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DECIM_FACTOR = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAP_COUNT    = 2'd2;

    // Command carried by an input beat.
    typedef enum logic [0:0] {
        CMD_LOAD_COEF   = 1'b0,
        CMD_PUSH_SAMPLE = 1'b1
    } prr_cmd_t;

    // Input beat.
    typedef struct packed {
        prr_cmd_t                            command;
        logic [COEF_INDEX_WIDTH-1:0]         coef_index;
        logic signed [SAMPLE_WIDTH-1:0]      value;
    } prr_in_t;

    // Output beat.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0]      out_sample;
        logic                                last_of_run;
    } prr_out_t;

    // Ratio registers act as 1 when zero and saturate at the largest ratio.
    function automatic logic [RATIO_WIDTH-1:0] clamp_ratio(input logic [RATIO_WIDTH-1:0] r);
        logic [RATIO_WIDTH-1:0] res;
        if (r == '0)
        begin
            res = RATIO_WIDTH'(1);
        end
        else if (r > RATIO_WIDTH'(RATIO_MAX))
        begin
            res = RATIO_WIDTH'(RATIO_MAX);
        end
        else
        begin
            res = r;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/polyphase_rational_resampler.sv @@
// ============================================================================
// polyphase_rational_resampler: rational up/decim resampler, polyphase FIR
// Coefficients and sample history live in two synchronous memories that one
// shared multiply-accumulate unit walks through, one tap per cycle.
// ============================================================================
//
// Usage: the input channel (in_valid / in_stall / in_beat) takes two kinds of
// beat. A coefficient load writes one Q1.15 coefficient. A sample push stores
// the sample in the history ring and then emits
// every output that falls in this sample's up-slot, zero to 32 of them, on
// the output channel (out_valid / out_stall / out_beat); last_of_run marks
// the final one. The configuration port writes up_factor, decim_factor and
// tap_count and must only be used while the block is idle.
// Operation: each output walks ceil((tap_count - phase) / up_factor) taps on
// the single MAC (one coefficient and one history read per cycle), then the
// pipeline drains and the sum is rounded. The block takes one beat at a
// time; in_stall is high from a sample push until its last output sits in
// the output register. A stalled receiver holds that register; the next
// result is computed meanwhile and waits until the register empties.
// Reset: registers return to 1 / 1 / 1, the history reads as zeros through a
// fill count (no clearing pass), coefficients are undefined until loaded.
//
`default_nettype none

module polyphase_rational_resampler
    import prr_pkg::*;
#(
    parameter int MAX_TAPS      = DEFAULT_MAX_TAPS,
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]   cfg_data,

    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire prr_in_t                     in_beat,

    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      prr_out_t                    out_beat
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int CAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW  = $clog2(HISTORY_DEPTH + 1);
    localparam int KW  = $clog2(MAX_TAPS + 2 * RATIO_MAX);
    localparam int AW  = 2 * SW + $clog2(MAX_TAPS);
    localparam int PW  = 2 * SW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Storage.
    logic signed [SW-1:0] coef_mem [MAX_TAPS];
    logic signed [SW-1:0] hist_mem [HISTORY_DEPTH];

    // Control and state registers.
    state_t                   state_reg;
    logic [RATIO_WIDTH-1:0]   up_factor_reg;
    logic [RATIO_WIDTH-1:0]   decim_factor_reg;
    logic [TAPS_WIDTH-1:0]    tap_count_reg;
    logic [HAW-1:0]           head_reg;
    logic [FW-1:0]            fill_reg;
    logic [PHASE_WIDTH-1:0]   phase_reg;
    logic [HAW-1:0]           newest_reg;
    logic [KW-1:0]            k_reg;
    logic [HAW-1:0]           pos_reg;
    logic [FW-1:0]            rem_reg;
    logic                     s1_vld_reg;
    logic                     s1_hv_reg;
    logic                     s2_vld_reg;
    logic signed [AW-1:0]     acc_reg;
    logic                     out_valid_reg;
    prr_out_t                 out_reg;

    // Datapath registers (no reset needed).
    logic signed [SW-1:0]     coef_rd_reg;
    logic signed [SW-1:0]     hist_rd_reg;
    logic signed [PW-1:0]     prod_reg;

    // Combinational helpers.
    logic [RATIO_WIDTH-1:0]   up_eff;
    logic [RATIO_WIDTH-1:0]   dec_eff;
    logic [KW-1:0]            taps_eff;
    logic                     in_accept;
    logic                     out_take;
    logic                     out_free;
    logic                     issue;
    logic [HAW-1:0]           head_next;
    logic [FW-1:0]            fill_next;
    logic [PHASE_WIDTH-1:0]   phase_next;
    logic                     coef_wr;
    logic [CAW-1:0]           coef_wr_addr;
    logic signed [AW-1:0]     acc_rnd;
    logic signed [AW-1:0]     acc_shr;
    logic signed [AW-1:0]     sat_hi;
    logic signed [AW-1:0]     sat_lo;
    logic signed [SW-1:0]     result;

    // Effective register values after range clamping.
    always_comb
    begin
        up_eff  = clamp_ratio(up_factor_reg);
        dec_eff = clamp_ratio(decim_factor_reg);
        if (tap_count_reg == '0)
        begin
            taps_eff = KW'(1);
        end
        else if (32'(tap_count_reg) > MAX_TAPS)
        begin
            taps_eff = KW'(MAX_TAPS);
        end
        else
        begin
            taps_eff = KW'(tap_count_reg);
        end
    end

    // Handshake terms.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    // One tap is issued per cycle while the phase's taps remain.
    assign issue = (state_reg == ST_RUN) && (k_reg < taps_eff);

    // History ring pointer, fill count and phase arithmetic.
    always_comb
    begin
        if (32'(head_reg) == HISTORY_DEPTH - 1)
        begin
            head_next = '0;
        end
        else
        begin
            head_next = head_reg + HAW'(1);
        end
        if (32'(fill_reg) == HISTORY_DEPTH)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + FW'(1);
        end
        phase_next = phase_reg + dec_eff;
    end

    // Coefficient write decode; loads beyond the store are dropped.
    assign coef_wr      = in_accept && (in_beat.command == CMD_LOAD_COEF)
                          && (32'(in_beat.coef_index) < MAX_TAPS);
    assign coef_wr_addr = CAW'(32'(in_beat.coef_index));

    // Coefficient memory: written only while idle, so reads never collide.
    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            coef_mem[coef_wr_addr] <= in_beat.value;
        end
        coef_rd_reg <= coef_mem[k_reg[CAW-1:0]];
    end

    // History memory: the newest sample is written the cycle before reads start.
    always_ff @(posedge clk)
    begin
        if (in_accept && (in_beat.command == CMD_PUSH_SAMPLE))
        begin
            hist_mem[head_reg] <= in_beat.value;
        end
        hist_rd_reg <= hist_mem[pos_reg];
    end

    // Multiplier stage; entries never written since reset read as zero.
    always_ff @(posedge clk)
    begin
        if (s1_hv_reg)
        begin
            prod_reg <= coef_rd_reg * hist_rd_reg;
        end
        else
        begin
            prod_reg <= '0;
        end
    end

    // Round half up to Q1.15 and saturate.
    always_comb
    begin
        sat_hi  = {{(AW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
        sat_lo  = ~sat_hi;
        acc_rnd = acc_reg + (AW'(1) <<< (SW - 2));
        acc_shr = acc_rnd >>> (SW - 1);
        if (acc_shr > sat_hi)
        begin
            result = sat_hi[SW-1:0];
        end
        else if (acc_shr < sat_lo)
        begin
            result = sat_lo[SW-1:0];
        end
        else
        begin
            result = acc_shr[SW-1:0];
        end
    end

    // Sequencer, configuration registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            up_factor_reg    <= RATIO_WIDTH'(1);
            decim_factor_reg <= RATIO_WIDTH'(1);
            tap_count_reg    <= TAPS_WIDTH'(1);
            head_reg         <= '0;
            fill_reg         <= '0;
            phase_reg        <= '0;
            newest_reg       <= '0;
            k_reg            <= '0;
            pos_reg          <= '0;
            rem_reg          <= '0;
            s1_vld_reg       <= 1'b0;
            s1_hv_reg        <= 1'b0;
            s2_vld_reg       <= 1'b0;
            acc_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
        end
        else
        begin
            // Configuration writes; unknown indexes are ignored.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_UP_FACTOR:    up_factor_reg    <= cfg_data[RATIO_WIDTH-1:0];
                    REG_DECIM_FACTOR: decim_factor_reg <= cfg_data[RATIO_WIDTH-1:0];
                    REG_TAP_COUNT:    tap_count_reg    <= cfg_data[TAPS_WIDTH-1:0];
                    default:          ;
                endcase
            end

            // The receiver drains the output register unless it refills now.
            if (out_take && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            // MAC pipeline: read, multiply, accumulate.
            s1_vld_reg <= issue;
            s1_hv_reg  <= issue && (rem_reg != '0);
            s2_vld_reg <= s1_vld_reg;
            if (s2_vld_reg)
            begin
                acc_reg <= acc_reg + {{(AW - PW){prod_reg[PW-1]}}, prod_reg};
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (in_beat.command == CMD_PUSH_SAMPLE))
                    begin
                        newest_reg <= head_reg;
                        head_reg   <= head_next;
                        fill_reg   <= fill_next;
                        if (phase_reg < up_eff)
                        begin
                            k_reg     <= KW'(phase_reg);
                            pos_reg   <= head_reg;
                            rem_reg   <= fill_next;
                            acc_reg   <= '0;
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            phase_reg <= phase_reg - up_eff;
                        end
                    end
                end

                ST_RUN:
                begin
                    if (issue)
                    begin
                        k_reg <= k_reg + KW'(up_eff);
                        if (pos_reg == '0)
                        begin
                            pos_reg <= HAW'(HISTORY_DEPTH - 1);
                        end
                        else
                        begin
                            pos_reg <= pos_reg - HAW'(1);
                        end
                        if (pos_reg == head_reg)
                        begin
                            // The walk wraps around onto the newest sample again.
                            rem_reg <= fill_reg;
                        end
                        else if (rem_reg != '0)
                        begin
                            rem_reg <= rem_reg - FW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end

                ST_DRAIN:
                begin
                    if (!s1_vld_reg && !s2_vld_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_reg.out_sample      <= result;
                        out_reg.last_of_run     <= (phase_next >= up_eff);
                        if (phase_next >= up_eff)
                        begin
                            phase_reg <= phase_next - up_eff;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            // Next phase of the same input sample.
                            phase_reg <= phase_next;
                            k_reg     <= KW'(phase_next);
                            pos_reg   <= newest_reg;
                            rem_reg   <= fill_reg;
                            acc_reg   <= '0;
                            state_reg <= ST_RUN;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
